// ----- rtl/chef_pkg.sv -----
// Shared types and constants of the canonical Huffman encoder.
package chef_pkg;

  localparam int SYM_W = 8;
  localparam int LEN_FIELD_W = 6;
  localparam int BYTE_W = 8;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_BUILD  = 2'd1,
    MODE_ENCODE = 2'd2,
    MODE_FINISH = 2'd3
  } mode_t;

  typedef struct packed {
    logic                   enc;
    logic                   fin;
    logic [LEN_FIELD_W-1:0] len;
  } pack_cmd_t;

endpackage

// ----- rtl/chef_if.sv -----
// Valid/ready channel interfaces for input items and output bytes.
interface chef_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      mode;
  logic [chef_pkg::SYM_W-1:0]      symbol;
  logic [chef_pkg::LEN_FIELD_W-1:0] code_length;

  modport source(output valid, mode, symbol, code_length, input ready);
  modport sink(input valid, mode, symbol, code_length, output ready);
endinterface

interface chef_out_if;
  logic                        valid;
  logic                        ready;
  logic [chef_pkg::BYTE_W-1:0] byte_value;
  logic                        is_trailer;
  logic                        last_of_run;

  modport source(output valid, byte_value, is_trailer, last_of_run, input ready);
  modport sink(input valid, byte_value, is_trailer, last_of_run, output ready);
endinterface

// ----- rtl/chef_len_table.sv -----
// Code length memory with per-entry valid bits so that unwritten entries read as zero.
module chef_len_table #(
  parameter int NUM_SYMBOLS = 256,
  parameter int AW = 8,
  parameter int LEN_W = 6
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [LEN_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [LEN_W-1:0] rdata
);

  logic [LEN_W-1:0]       mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] written;
  logic [LEN_W-1:0]       rd_q;
  logic                   rd_vld;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_vld <= written[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

// ----- rtl/chef_code_table.sv -----
// Canonical code memory with one write port and a registered read port.
module chef_code_table #(
  parameter int NUM_SYMBOLS = 256,
  parameter int AW = 8,
  parameter int CODE_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CODE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [CODE_W-1:0] rdata
);

  logic [CODE_W-1:0] mem [NUM_SYMBOLS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/chef_packer.sv -----
// Bit packer that appends codes MSB first and emits bytes, flush bytes and trailers.
module chef_packer #(
  parameter int MAX_CODE_LEN = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  chef_pkg::pack_cmd_t      cmd,
  input  logic [MAX_CODE_LEN-1:0]  code,
  output logic                     busy,
  chef_out_if.source               dout
);

  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);
  localparam int WW = MAX_CODE_LEN + 8;
  localparam int TW = $clog2(MAX_CODE_LEN + 16);

  typedef enum logic [3:0] {
    P_IDLE  = 4'b0001,
    P_EMIT  = 4'b0010,
    P_FIN   = 4'b0100,
    P_TRAIL = 4'b1000
  } pstate_t;

  pstate_t pstate, pstate_next;

  // The pending bits are kept left aligned, so a flush byte needs no shift.
  logic [6:0]              acc, acc_next;
  logic [2:0]              pend, pend_next;
  logic [WW-1:0]           win;
  logic [TW-1:0]           total;
  logic                    ov;
  logic [7:0]              obyte;
  logic                    otrl;
  logic                    olast;

  logic [LEN_W-1:0]        len;
  logic [MAX_CODE_LEN-1:0] code_l;
  logic [WW-1:0]           win_new;
  logic [TW-1:0]           tot_new;
  logic                    slot;
  logic                    load_win;
  logic                    emit;
  logic [7:0]              ebyte;
  logic                    etrl;
  logic                    elast;

  assign len     = cmd.len[LEN_W-1:0];
  assign code_l  = code << (LEN_W'(MAX_CODE_LEN) - len);
  assign win_new = {acc, {(WW-7){1'b0}}} | ({code_l, 8'h00} >> pend);
  assign tot_new = TW'(pend) + TW'(len);
  assign slot    = !ov || dout.ready;

  always_comb begin
    pstate_next = pstate;
    acc_next    = acc;
    pend_next   = pend;
    load_win    = 1'b0;
    emit        = 1'b0;
    ebyte       = win[WW-1 -: 8];
    etrl        = 1'b0;
    elast       = 1'b0;
    case (pstate)
      P_IDLE: begin
        if (cmd.enc) begin
          if (tot_new < TW'(8)) begin
            acc_next  = win_new[WW-1 -: 7];
            pend_next = tot_new[2:0];
          end else begin
            load_win    = 1'b1;
            pstate_next = P_EMIT;
          end
        end else if (cmd.fin) begin
          pstate_next = P_FIN;
        end
      end
      P_EMIT: begin
        if (slot) begin
          emit  = 1'b1;
          elast = (total < TW'(16));
          if (total < TW'(16)) begin
            acc_next    = win[WW-9 -: 7];
            pend_next   = total[2:0];
            pstate_next = P_IDLE;
          end
        end
      end
      P_FIN: begin
        if (slot) begin
          emit = 1'b1;
          if (pend != 3'd0) begin
            ebyte       = {acc, 1'b0};
            pstate_next = P_TRAIL;
          end else begin
            ebyte       = 8'h00;
            etrl        = 1'b1;
            elast       = 1'b1;
            pstate_next = P_IDLE;
          end
        end
      end
      P_TRAIL: begin
        if (slot) begin
          emit        = 1'b1;
          ebyte       = {5'b00000, pend};
          etrl        = 1'b1;
          elast       = 1'b1;
          acc_next    = 7'h00;
          pend_next   = 3'd0;
          pstate_next = P_IDLE;
        end
      end
      default: begin
        pstate_next = P_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate <= P_IDLE;
      acc    <= 7'h00;
      pend   <= 3'd0;
      ov     <= 1'b0;
    end else begin
      pstate <= pstate_next;
      acc    <= acc_next;
      pend   <= pend_next;
      if (emit) begin
        ov <= 1'b1;
      end else if (dout.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_win) begin
      win   <= win_new;
      total <= tot_new;
    end else if (emit && pstate == P_EMIT) begin
      win   <= win << 8;
      total <= total - TW'(8);
    end
    if (emit) begin
      obyte <= ebyte;
      otrl  <= etrl;
      olast <= elast;
    end
  end

  assign busy             = (pstate != P_IDLE);
  assign dout.valid       = ov;
  assign dout.byte_value  = obyte;
  assign dout.is_trailer  = otrl;
  assign dout.last_of_run = olast;

endmodule

// ----- rtl/canonical_huffman_encoder.sv -----
// Top level of the canonical Huffman encoder: item decode, code build sweep and tables.
// A load item writes the length table; lengths above MAX_CODE_LEN are
// stored as MAX_CODE_LEN. A build item sweeps the length table once per
// code length, one entry read per cycle from its single read port, and
// writes every code table entry. An encode item looks up the length and
// code tables, then the packer moves one byte per cycle into its output
// register while the output is not stalled (up to four bytes for a 32-bit
// code). A finish item sends the zero-padded partial byte if any and then
// the trailer byte, one per cycle while the output is not stalled. The
// length table comes out of reset empty with no clearing pass; codes are
// valid only after a build.
module canonical_huffman_encoder #(
  parameter int NUM_SYMBOLS = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input  logic      clk,
  input  logic      rst,
  chef_in_if.sink   din,
  chef_out_if.source dout
);

  localparam int AW = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_BUILD = 4'b0100,
    S_DRAIN = 4'b1000
  } state_t;

  state_t state;

  logic                    accept;
  logic                    sym_ok;
  logic                    enc_ok;
  logic                    pk_busy;
  chef_pkg::pack_cmd_t     cmd;

  logic                    len_we;
  logic [LEN_W-1:0]        len_wdata;
  logic [AW-1:0]           len_raddr;
  logic [LEN_W-1:0]        len_rd;

  logic [MAX_CODE_LEN-1:0] code_rd;
  logic                    code_we;
  logic [MAX_CODE_LEN-1:0] code_wdata;

  logic [AW-1:0]           bsym;
  logic [LEN_W-1:0]        blen;
  logic                    last_sym;
  logic                    p1;
  logic [AW-1:0]           p1_sym;
  logic [LEN_W-1:0]        p1_len;
  logic                    p1_end;
  logic                    match;
  logic [MAX_CODE_LEN-1:0] counter, counter_next;

  assign accept = din.valid && din.ready;
  assign din.ready = (state == S_IDLE) && !pk_busy;
  assign sym_ok = ({1'b0, din.symbol} < 9'(NUM_SYMBOLS));

  assign len_we    = accept && (din.mode == chef_pkg::MODE_LOAD) && sym_ok;
  assign len_wdata = (din.code_length > 6'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                          : din.code_length[LEN_W-1:0];
  assign len_raddr = (state == S_BUILD) ? bsym : din.symbol[AW-1:0];

  chef_len_table #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .AW(AW),
    .LEN_W(LEN_W)
  ) u_len_table (
    .clk(clk),
    .rst(rst),
    .we(len_we),
    .waddr(din.symbol[AW-1:0]),
    .wdata(len_wdata),
    .raddr(len_raddr),
    .rdata(len_rd)
  );

  // The first pass also clears the codes of absent symbols.
  assign last_sym   = (bsym == AW'(NUM_SYMBOLS - 1));
  assign match      = p1 && (len_rd == p1_len);
  assign code_we    = p1 && (match || p1_len == LEN_W'(1));
  assign code_wdata = match ? counter : '0;

  always_comb begin
    counter_next = counter + MAX_CODE_LEN'(match);
    if (p1 && p1_end) begin
      counter_next = counter_next << 1;
    end
  end

  chef_code_table #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .AW(AW),
    .CODE_W(MAX_CODE_LEN)
  ) u_code_table (
    .clk(clk),
    .we(code_we),
    .waddr(p1_sym),
    .wdata(code_wdata),
    .raddr(din.symbol[AW-1:0]),
    .rdata(code_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      p1    <= 1'b0;
    end else begin
      p1 <= (state == S_BUILD);
      case (state)
        S_IDLE: begin
          if (accept && din.mode == chef_pkg::MODE_BUILD) begin
            state <= S_BUILD;
          end else if (accept && din.mode == chef_pkg::MODE_ENCODE) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          state <= S_IDLE;
        end
        S_BUILD: begin
          if (last_sym && blen == LEN_W'(MAX_CODE_LEN)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    p1_sym <= bsym;
    p1_len <= blen;
    p1_end <= last_sym;
    if (state == S_IDLE) begin
      bsym    <= '0;
      blen    <= LEN_W'(1);
      counter <= '0;
      enc_ok  <= sym_ok;
    end else begin
      counter <= counter_next;
      if (state == S_BUILD) begin
        if (last_sym) begin
          bsym <= '0;
          blen <= blen + LEN_W'(1);
        end else begin
          bsym <= bsym + AW'(1);
        end
      end
    end
  end

  always_comb begin
    cmd.enc = (state == S_LOOK) && enc_ok && (len_rd != '0);
    cmd.fin = accept && (din.mode == chef_pkg::MODE_FINISH);
    cmd.len = chef_pkg::LEN_FIELD_W'(len_rd);
  end

  chef_packer #(
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) u_packer (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .code(code_rd),
    .busy(pk_busy),
    .dout(dout)
  );

endmodule

// ----- rtl/chef_checker.sv -----
// Port-level assertions for the canonical Huffman encoder and their binding.
module chef_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_trailer,
  input logic       out_last
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output beat valid right after reset");

  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_mode != chef_pkg::MODE_LOAD |=> !in_ready)
    else $error("input ready while an item is still at work");

  a_trailer_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_trailer |-> out_last && out_byte[7:3] == 5'b00000)
    else $error("trailer beat malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_trailer)
      && $stable(out_last))
    else $error("stalled output beat changed");

endmodule

bind canonical_huffman_encoder chef_checker u_chef_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(din.valid),
  .in_ready(din.ready),
  .in_mode(din.mode),
  .out_valid(dout.valid),
  .out_ready(dout.ready),
  .out_byte(dout.byte_value),
  .out_trailer(dout.is_trailer),
  .out_last(dout.last_of_run)
);

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the canonical Huffman encoder: directed and random item streams.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SYMBOLS = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int ITEM_TARGET = 270;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int TAIL_CYCLES = 32;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       is_trailer;
    logic       last_of_run;
  } byte_beat_t;

  logic clk;
  logic rst;

  chef_in_if  din_if();
  chef_out_if dout_if();

  canonical_huffman_encoder #(
    .NUM_SYMBOLS(NUM_SYMBOLS),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .din(din_if),
    .dout(dout_if)
  );

  logic [5:0]  length_of[NUM_SYMBOLS];
  logic [31:0] code_of[NUM_SYMBOLS];
  logic [6:0]  held_bits;
  logic [2:0]  held_count;
  byte_beat_t  awaited_bytes[$];

  int unsigned items_sent;
  int unsigned bytes_checked;
  int unsigned builds_done;
  int unsigned finishes_done;
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          no_idle;

  function automatic int unsigned draw_wait();
    if (no_idle) return 0;
    return $urandom_range(0, 14);
  endfunction

  function automatic void build_code_table();
    logic [63:0] counter;
    counter = '0;
    for (int s = 0; s < NUM_SYMBOLS; s++) code_of[s] = '0;
    for (int len = 1; len <= MAX_CODE_LEN; len++) begin
      for (int s = 0; s < NUM_SYMBOLS; s++) begin
        if (length_of[s] == len) begin
          code_of[s] = counter[31:0];
          counter = counter + 64'd1;
        end
      end
      counter = counter << 1;
    end
  endfunction

  function automatic void encode_symbol_bytes(logic [7:0] sym);
    int unsigned len;
    int unsigned total;
    int unsigned nbytes;
    logic [63:0] code;
    logic [63:0] bits;
    logic [63:0] shifted;
    byte_beat_t  beat;
    len = length_of[sym];
    if (len == 0) return;
    code = {32'd0, code_of[sym]} & ((64'd1 << len) - 64'd1);
    bits = ({57'd0, held_bits} << len) | code;
    total = held_count + len;
    nbytes = total / 8;
    for (int k = 0; k < nbytes; k++) begin
      shifted = bits >> (total - 8 * (k + 1));
      beat.byte_value = shifted[7:0];
      beat.is_trailer = 1'b0;
      beat.last_of_run = (k == nbytes - 1);
      awaited_bytes.push_back(beat);
    end
    total = total % 8;
    bits = bits & ((64'd1 << total) - 64'd1);
    held_bits = bits[6:0];
    held_count = total[2:0];
  endfunction

  function automatic void finish_stream_bytes();
    logic [15:0] padded;
    byte_beat_t  beat;
    if (held_count != 0) begin
      padded = {9'd0, held_bits} << (8 - held_count);
      beat.byte_value = padded[7:0];
      beat.is_trailer = 1'b0;
      beat.last_of_run = 1'b0;
      awaited_bytes.push_back(beat);
    end
    beat.byte_value = {5'd0, held_count};
    beat.is_trailer = 1'b1;
    beat.last_of_run = 1'b1;
    awaited_bytes.push_back(beat);
    held_bits = '0;
    held_count = '0;
  endfunction

  function automatic void predict_item(chef_pkg::mode_t mode, logic [7:0] sym,
                                       logic [5:0] clen);
    case (mode)
      chef_pkg::MODE_LOAD: begin
        length_of[sym] = (clen > MAX_CODE_LEN) ? 6'(MAX_CODE_LEN) : clen;
      end
      chef_pkg::MODE_BUILD: begin
        build_code_table();
        builds_done++;
      end
      chef_pkg::MODE_ENCODE: begin
        encode_symbol_bytes(sym);
      end
      default: begin
        finish_stream_bytes();
        finishes_done++;
      end
    endcase
  endfunction

  task automatic send_item(chef_pkg::mode_t mode, logic [7:0] sym, logic [5:0] clen);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      din_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din_if.valid <= 1'b1;
    din_if.mode <= mode;
    din_if.symbol <= sym;
    din_if.code_length <= clen;
    do @(posedge clk); while (!din_if.ready);
    predict_item(mode, sym, clen);
    items_sent++;
  endtask

  task automatic wait_all_bytes();
    din_if.valid <= 1'b0;
    do @(posedge clk); while (awaited_bytes.size() != 0);
  endtask

  task automatic check_byte(byte_beat_t got);
    byte_beat_t want;
    if (awaited_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Unexpected beat: value %h trailer %b last %b",
                 got.byte_value, got.is_trailer, got.last_of_run);
      return;
    end
    want = awaited_bytes.pop_front();
    bytes_checked++;
    if (got.byte_value !== want.byte_value || got.is_trailer !== want.is_trailer ||
        got.last_of_run !== want.last_of_run) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Beat %0d: expected value %h trailer %b last %b, got value %h trailer %b last %b",
                 bytes_checked, want.byte_value, want.is_trailer, want.last_of_run,
                 got.byte_value, got.is_trailer, got.last_of_run);
    end
  endtask

  task automatic test_empty_table();
    send_item(chef_pkg::MODE_BUILD, 8'd0, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd0, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd255, 6'd63);
    send_item(chef_pkg::MODE_FINISH, 8'd0, 6'd0);
  endtask

  task automatic test_directed_codes();
    send_item(chef_pkg::MODE_LOAD, 8'd0, 6'd1);
    send_item(chef_pkg::MODE_LOAD, 8'd255, 6'd32);
    send_item(chef_pkg::MODE_LOAD, 8'd128, 6'd40);
    send_item(chef_pkg::MODE_LOAD, 8'd1, 6'd63);
    send_item(chef_pkg::MODE_LOAD, 8'd170, 6'd7);
    send_item(chef_pkg::MODE_LOAD, 8'd85, 6'd3);
    send_item(chef_pkg::MODE_LOAD, 8'd3, 6'd5);
    send_item(chef_pkg::MODE_LOAD, 8'd3, 6'd0);
    send_item(chef_pkg::MODE_BUILD, 8'd255, 6'd63);
    send_item(chef_pkg::MODE_ENCODE, 8'd0, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd255, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd170, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd128, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd3, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd170, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd1, 6'd0);
    send_item(chef_pkg::MODE_FINISH, 8'd0, 6'd0);
    send_item(chef_pkg::MODE_FINISH, 8'd255, 6'd63);
    wait_all_bytes();
  endtask

  task automatic test_stale_codes();
    no_idle = 1'b1;
    send_item(chef_pkg::MODE_LOAD, 8'd170, 6'd12);
    send_item(chef_pkg::MODE_ENCODE, 8'd170, 6'd0);
    send_item(chef_pkg::MODE_LOAD, 8'd255, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd255, 6'd0);
    send_item(chef_pkg::MODE_ENCODE, 8'd85, 6'd0);
    send_item(chef_pkg::MODE_FINISH, 8'd0, 6'd0);
    wait_all_bytes();
    no_idle = 1'b0;
  endtask

  task automatic run_random_phase();
    int unsigned leaves;
    int unsigned kind;
    int unsigned idx;
    int unsigned roll;
    int          v;
    int          lens[$];
    logic [7:0]  syms[$];
    bit          taken[NUM_SYMBOLS];
    logic [7:0]  s;
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < NUM_SYMBOLS; i++)
      if (length_of[i] != 0) send_item(chef_pkg::MODE_LOAD, 8'(i), 6'd0);
    kind = $urandom_range(0, 3);
    leaves = $urandom_range(2, 10);
    if (kind == 3) begin
      repeat (leaves) lens.push_back($urandom_range(0, 63));
    end else begin
      lens = {1, 1};
      while (lens.size() < leaves) begin
        idx = 0;
        if (kind == 2) begin
          foreach (lens[j]) if (lens[j] > lens[idx]) idx = j;
        end else begin
          idx = $urandom_range(0, lens.size() - 1);
        end
        v = lens[idx];
        lens.delete(idx);
        lens.push_back(v + 1);
        lens.push_back(v + 1);
      end
    end
    foreach (lens[k]) begin
      do s = 8'($urandom_range(0, 255)); while (taken[s]);
      taken[s] = 1'b1;
      syms.push_back(s);
      send_item(chef_pkg::MODE_LOAD, s, 6'(lens[k]));
    end
    send_item(chef_pkg::MODE_BUILD, 8'($urandom), 6'($urandom));
    repeat ($urandom_range(12, 24)) begin
      roll = $urandom_range(0, 99);
      if (roll < 80)
        send_item(chef_pkg::MODE_ENCODE, syms[$urandom_range(0, syms.size() - 1)],
                  6'($urandom));
      else if (roll < 88)
        send_item(chef_pkg::MODE_ENCODE, 8'($urandom), 6'($urandom));
      else if (roll < 94)
        send_item(chef_pkg::MODE_FINISH, 8'($urandom), 6'($urandom));
      else
        send_item(chef_pkg::MODE_LOAD, syms[$urandom_range(0, syms.size() - 1)],
                  6'($urandom_range(0, 63)));
    end
    send_item(chef_pkg::MODE_FINISH, 8'($urandom), 6'($urandom));
    wait_all_bytes();
  endtask

  task automatic test_random_streams();
    while (items_sent < ITEM_TARGET) run_random_phase();
    no_idle = 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d beats outstanding",
             cycle_count, awaited_bytes.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin : byte_checker
    byte_beat_t  got;
    int unsigned stall;
    dout_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        dout_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dout_if.ready <= 1'b1;
      do @(posedge clk); while (!dout_if.valid);
      got.byte_value = dout_if.byte_value;
      got.is_trailer = dout_if.is_trailer;
      got.last_of_run = dout_if.last_of_run;
      check_byte(got);
    end
  end

  initial begin
    rst <= 1'b1;
    din_if.valid <= 1'b0;
    din_if.mode <= chef_pkg::MODE_LOAD;
    din_if.symbol <= '0;
    din_if.code_length <= '0;
    for (int s = 0; s < NUM_SYMBOLS; s++) begin
      length_of[s] = '0;
      code_of[s] = '0;
    end
    held_bits = '0;
    held_count = '0;
    items_sent = 0;
    bytes_checked = 0;
    builds_done = 0;
    finishes_done = 0;
    mismatches = 0;
    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_directed_codes();
    test_stale_codes();
    test_random_streams();
    wait_all_bytes();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Sent %0d items with %0d code builds and %0d stream finishes; checked %0d beats.",
             items_sent, builds_done, finishes_done, bytes_checked);
    $display("Streams covered empty, saturated, over-full and stale code tables.");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatching beats", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
